/* design/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types, constants and helper functions shared by the UTF-8 decoder files.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 32;
    localparam int CNT_W  = 2;

    // Per-string decode state
    typedef struct packed {
        logic [CP_W-1:0]  acc;        // bytes of the sequence being built
        logic [CNT_W-1:0] remaining;  // continuation bytes still expected
        logic [CNT_W-1:0] trailers;   // trailing count of current sequence
        logic             err_seen;   // sticky error for this string
    } t_dec_state;

    // One result beat
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            error;
        logic            eos;
    } t_result;

    // Offsets removed from the raw accumulation, indexed by trailing count
    localparam logic [CP_W-1:0] SEQ_OFFSET_0 = '0;
    localparam logic [CP_W-1:0] SEQ_OFFSET_1 = CP_W'((32'hC0 << 6) | 32'h80);
    localparam logic [CP_W-1:0] SEQ_OFFSET_2 =
        CP_W'((32'hE0 << 12) | (32'h80 << 6) | 32'h80);
    localparam logic [CP_W-1:0] SEQ_OFFSET_3 =
        CP_W'((32'hF0 << 18) | (32'h80 << 12) | (32'h80 << 6) | 32'h80);

    // First byte value that is never a valid lead
    localparam logic [BYTE_W-1:0] BAD_LEAD_MIN = 8'hF8;

    function automatic logic [CP_W-1:0] seq_offset(input logic [CNT_W-1:0] trl);
        logic [CP_W-1:0] off;
        unique case (trl)
            2'd0:    off = SEQ_OFFSET_0;
            2'd1:    off = SEQ_OFFSET_1;
            2'd2:    off = SEQ_OFFSET_2;
            default: off = SEQ_OFFSET_3;
        endcase
        return off;
    endfunction

    // Trailing count from the lead byte (bad leads handled by the caller)
    function automatic logic [CNT_W-1:0] lead_trailers(input logic [BYTE_W-1:0] b);
        logic [CNT_W-1:0] t;
        priority if (b >= 8'hF0) begin
            t = 2'd3;
        end else if (b >= 8'hE0) begin
            t = 2'd2;
        end else if (b >= 8'hC0) begin
            t = 2'd1;
        end else begin
            t = 2'd0;
        end
        return t;
    endfunction

endpackage

/* design/utf8d_core.sv */
// ----------------------------------------------------------------------------
// utf8d_core
// Decode state register and the single-pass step logic: one byte in,
// at most one result out per cycle in which i_step is high.
// ----------------------------------------------------------------------------
module utf8d_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,       // consume one byte
    input  logic [utf8d_pkg::BYTE_W-1:0]  i_byte,
    input  logic                          i_last,
    output logic                          o_res_valid,  // result for this byte
    output utf8d_pkg::t_result            o_res,
    output utf8d_pkg::t_dec_state         o_state
);
    import utf8d_pkg::*;

    t_dec_state r_state;
    t_dec_state n_state;

    logic [CP_W-1:0]  acc_next;
    logic [CNT_W-1:0] rem_next;
    logic [CNT_W-1:0] lead_trl;
    logic [CP_W-1:0]  code_val;

    // Datapath pieces
    assign acc_next = {r_state.acc[CP_W-7:0], 6'b0} + CP_W'(i_byte);
    assign rem_next = r_state.remaining - 2'd1;
    assign lead_trl = lead_trailers(i_byte);
    assign code_val = acc_next - seq_offset(r_state.trailers);

    // Step logic
    always_comb begin
        n_state     = r_state;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (r_state.err_seen) begin
            // silent until the last byte, then one error beat
            if (i_last) begin
                o_res_valid = 1'b1;
                o_res.error = 1'b1;
                o_res.eos   = 1'b1;
                n_state     = '0;
            end
        end else if (r_state.remaining == '0) begin
            if (i_byte >= BAD_LEAD_MIN) begin
                n_state.err_seen = 1'b1;
                if (i_last) begin
                    o_res_valid = 1'b1;
                    o_res.error = 1'b1;
                    o_res.eos   = 1'b1;
                    n_state     = '0;
                end
            end else if (lead_trl == '0) begin
                // single-byte sequence, passed through
                o_res_valid      = 1'b1;
                o_res.code_point = CP_W'(i_byte);
                o_res.eos        = i_last;
                if (i_last) begin
                    n_state = '0;
                end
            end else begin
                n_state.acc       = CP_W'(i_byte);
                n_state.remaining = lead_trl;
                n_state.trailers  = lead_trl;
                if (i_last) begin
                    // truncated
                    o_res_valid = 1'b1;
                    o_res.error = 1'b1;
                    o_res.eos   = 1'b1;
                    n_state     = '0;
                end
            end
        end else if (rem_next == '0) begin
            // sequence complete
            o_res_valid      = 1'b1;
            o_res.code_point = code_val;
            o_res.eos        = i_last;
            n_state.acc       = '0;
            n_state.remaining = '0;
            n_state.trailers  = '0;
            if (i_last) begin
                n_state = '0;
            end
        end else begin
            n_state.acc       = acc_next;
            n_state.remaining = rem_next;
            if (i_last) begin
                o_res_valid = 1'b1;
                o_res.error = 1'b1;
                o_res.eos   = 1'b1;
                n_state     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

/* design/utf8_to_utf32_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder
// Streaming UTF-8 to UTF-32 decoder with an input register and a result
// register around single-pass step logic.
// ----------------------------------------------------------------------------
// One UTF-8 byte is taken per input beat (tlast marks the last byte of a
// string) and a decoded 32-bit code point leaves on the output when a
// sequence completes. The block accepts one byte every cycle unless
// the output stalls; a byte passes through the input register and then
// the result register, which holds its result. Continuation bytes are
// not checked. A lead byte of 0xF8-0xFF or a string that ends inside a
// sequence sets an error: the block then stays silent until the last byte
// and gives one beat with tuser high, tlast high and tdata zero. Code points
// sent before that beat should be dropped by the consumer.
module utf8_to_utf32_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input stream
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [utf8d_pkg::BYTE_W-1:0] i_s_tdata,   // [7:0] byte_value
    input  logic                         i_s_tlast,   // last_byte
    // output stream
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [utf8d_pkg::CP_W-1:0]   o_m_tdata,   // [31:0] code_point
    output logic                         o_m_tuser,   // [0] error
    output logic                         o_m_tlast    // end_of_string
);
    import utf8d_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out;

    logic       advance;
    logic       res_valid;
    t_result    res;
    t_dec_state dec_state;

    // The held byte moves on when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    utf8d_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_state     (dec_state)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.code_point;
    assign o_m_tuser  = r_out.error;
    assign o_m_tlast  = r_out.eos;

`ifndef ASSERT_OFF
    // an error beat always closes the string and carries no code point
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tlast && o_m_tdata == '0))
        else $error("error beat without end mark or with nonzero data");

    // the last byte of a string always gives a result
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |-> res_valid)
        else $error("last byte produced no result");

    // decode state is clean after the last byte of a string
    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (dec_state == '0))
        else $error("decode state not cleared after end of string");

    // no open sequence while in the error state
    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dec_state.err_seen |-> (dec_state.remaining == '0))
        else $error("error state with sequence still open");
`endif

endmodule
